// ===== design/crrnp_pkg.sv =====
// ----------------------------------------------------------------------------
// crrnp_pkg: shared types and constants of the credit round-robin node picker
// Field widths, command and register codes, controller states and the
// request bundle that the controller sends to the credit store.
// ----------------------------------------------------------------------------
package crrnp_pkg;

  localparam int NODE_W        = 5;
  localparam int CREDIT_W      = 8;
  localparam int ADDR_W        = 32;
  localparam int CMD_W         = 3;
  localparam int DIM_W         = 3;
  localparam int CNT_W         = NODE_W + 1;
  // Node indices are five bits wide, so no more entries than this can be named.
  localparam int NODE_LIMIT    = 1 << NODE_W;
  localparam int MAX_NODES_DEF = 32;

  localparam int S_TDATA_W = 80;  // 77 bits of fields, padded to whole bytes
  localparam int M_TDATA_W = 48;  // 46 bits of fields, padded to whole bytes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLAIM         = 3'd0,
    CMD_PROBE         = 3'd1,
    CMD_LOAD_CREDIT   = 3'd2,
    CMD_SET_PTR       = 3'd3,
    CMD_LOAD_DEFAULTS = 3'd4
  } crrnp_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_NODE = 1'd0,
    CFG_CUBE_DIM = 1'd1
  } crrnp_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } crrnp_state_e;

  typedef struct packed {
    logic                wr_en;
    logic [NODE_W-1:0]   wr_node;
    logic [CREDIT_W-1:0] wr_credit;
    logic                dflt_en;
    logic                rd_en;
    logic [NODE_W-1:0]   rd_node;
  } crrnp_store_req_t;

endpackage

// ===== design/crrnp_credit_store.sv =====
// ----------------------------------------------------------------------------
// crrnp_credit_store: per-node credit memory
// One synchronous memory with a registered read. Per-entry valid bits and a
// default mask give the cleared and neighbor-default contents without a sweep.
// ----------------------------------------------------------------------------
module crrnp_credit_store
  import crrnp_pkg::*;
#(
  parameter int DEPTH = MAX_NODES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crrnp_store_req_t     req_i,
  input  logic [DEPTH-1:0]     dflt_mask_i,
  output logic [CREDIT_W-1:0]  rd_credit_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CREDIT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [DEPTH-1:0]    dflt_q;
  logic [CREDIT_W-1:0] rd_data_q;
  logic                rd_valid_q;
  logic                rd_dflt_q;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;

  assign wr_addr = req_i.wr_node[AW-1:0];
  assign rd_addr = req_i.rd_node[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr] <= req_i.wr_credit;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      dflt_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_dflt_q  <= 1'b0;
    end else begin
      if (req_i.dflt_en) begin
        valid_q <= '0;
        dflt_q  <= dflt_mask_i;
      end else if (req_i.wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
        rd_dflt_q  <= dflt_q[rd_addr];
      end
    end
  end

  // An entry never written since reset or the last default load reads as
  // its default: one for a hypercube neighbor, zero otherwise.
  assign rd_credit_o = rd_valid_q ? rd_data_q : {{(CREDIT_W-1){1'b0}}, rd_dflt_q};

endmodule

// ===== design/credit_round_robin_node_picker_unit.sv =====
// ----------------------------------------------------------------------------
// credit_round_robin_node_picker_unit: credit-based round-robin node picker
// Claim and probe scan the credit memory one entry per cycle from the pointer
// over at most N entries, N the node count (at most 32), and stop at the first
// entry of another node with nonzero credit. Load, set and default commands
// go through the execute and response states. One item is in work at a time.
// Reset clears all credits, the pointer and both registers at once.
// ----------------------------------------------------------------------------
module credit_round_robin_node_picker_unit
  import crrnp_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // node_index[4:0], credit_value[12:5], local_addr[44:13],
  // continue_addr[76:45], zero padding[79:77]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[2:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // granted[0], dest_node[5:1], next_addr[37:6], credit_after[45:38],
  // zero padding[47:46]
  output logic [M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int DEPTH   = (MAX_NODES < NODE_LIMIT) ? MAX_NODES : NODE_LIMIT;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_LOG = $clog2(MAX_NODES + 1) - 1;
  localparam int DIM_CAP = (CAP_LOG < NODE_W) ? CAP_LOG : NODE_W;
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [DIM_W-1:0] DIM_CAP_C = DIM_W'(DIM_CAP);

  crrnp_state_e        state_q, state_d;
  crrnp_store_req_t    store_req;
  logic [DEPTH-1:0]    nb_mask;
  logic [CREDIT_W-1:0] rd_credit;

  logic [NODE_W-1:0]   own_q;
  logic [DIM_W-1:0]    dim_q;
  logic [NODE_W-1:0]   ptr_q, ptr_d;

  logic [CMD_W-1:0]    cmd_q;
  logic [NODE_W-1:0]   nidx_q;
  logic [CREDIT_W-1:0] cval_q;
  logic [ADDR_W-1:0]   laddr_q;
  logic [ADDR_W-1:0]   caddr_q;
  logic [NODE_W-1:0]   start_q;

  logic [CNT_W-1:0]    k_q;
  logic                chk_vld_q;
  logic [NODE_W-1:0]   chk_idx_q;
  logic                chk_last_q;
  logic                gnt_q;
  logic [NODE_W-1:0]   node_q;
  logic [CREDIT_W-1:0] cafter_q;

  logic                m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  logic [DIM_W-1:0]    n_log;
  logic [CNT_W-1:0]    n_nodes;
  logic [NODE_W-1:0]   n_mask;
  logic                accept;
  logic                issue;
  logic [NODE_W-1:0]   rd_idx;
  logic                hit;
  logic                miss_done;
  logic                out_free;
  logic                load_out;
  logic                is_claim;

  // Node count: 2^dimension, capped by the storage and the node index width.
  assign n_log   = (dim_q > DIM_CAP_C) ? DIM_CAP_C : dim_q;
  assign n_nodes = CNT_W'(1) << n_log;
  assign n_mask  = NODE_W'(n_nodes - CNT_W'(1));

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_claim  = (cmd_q == CMD_CLAIM);
  assign issue     = (state_q == ST_SCAN) && (k_q < n_nodes);
  assign rd_idx    = (start_q + k_q[NODE_W-1:0]) & n_mask;
  assign hit       = chk_vld_q && (chk_idx_q != own_q) && (rd_credit != '0);
  assign miss_done = chk_vld_q && chk_last_q && !hit;
  assign out_free  = !m_valid_q || m_axis_tready;

  always_comb begin
    logic [NODE_W-1:0] nb;
    nb      = '0;
    nb_mask = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if ((CNT_W'(1) << i) < n_nodes) begin
        nb = own_q ^ NODE_W'(1 << i);
        if ({1'b0, nb} < DEPTH_C) begin
          nb_mask[nb[AW-1:0]] = 1'b1;
        end
      end
    end
  end

  crrnp_credit_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (store_req),
    .dflt_mask_i (nb_mask),
    .rd_credit_o (rd_credit)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == CMD_CLAIM || s_axis_tuser == CMD_PROBE) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC:   state_d = ST_RESP;
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_UPDATE;
        end else if (miss_done) begin
          state_d = ST_RESP;
        end
      end
      ST_UPDATE: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    s_axis_tready       = 1'b0;
    load_out            = 1'b0;
    ptr_d               = ptr_q;
    store_req           = '0;
    store_req.rd_en     = issue;
    store_req.rd_node   = rd_idx;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: begin
        case (cmd_q)
          CMD_LOAD_CREDIT: begin
            store_req.wr_en     = ({1'b0, nidx_q} < DEPTH_C);
            store_req.wr_node   = nidx_q;
            store_req.wr_credit = cval_q;
          end
          CMD_SET_PTR: ptr_d = nidx_q;
          CMD_LOAD_DEFAULTS: begin
            store_req.dflt_en = 1'b1;
            ptr_d             = (own_q + NODE_W'(1)) & n_mask;
          end
          default: ;
        endcase
      end
      ST_SCAN: ;
      ST_UPDATE: begin
        if (is_claim) begin
          store_req.wr_en     = 1'b1;
          store_req.wr_node   = node_q;
          store_req.wr_credit = cafter_q - CREDIT_W'(1);
          ptr_d               = (node_q + NODE_W'(1)) & n_mask;
        end
      end
      ST_RESP: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      own_q     <= '0;
      dim_q     <= '0;
      ptr_q     <= '0;
      k_q       <= '0;
      chk_vld_q <= 1'b0;
      gnt_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_NODE: own_q <= cfg_data_i[NODE_W-1:0];
          CFG_CUBE_DIM: dim_q <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        k_q       <= '0;
        chk_vld_q <= 1'b0;
        gnt_q     <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (issue) begin
          k_q <= k_q + CNT_W'(1);
        end
        chk_vld_q <= issue && !hit;
        if (hit) begin
          gnt_q <= 1'b1;
        end
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= s_axis_tuser;
      nidx_q   <= s_axis_tdata[4:0];
      cval_q   <= s_axis_tdata[12:5];
      laddr_q  <= s_axis_tdata[44:13];
      caddr_q  <= s_axis_tdata[76:45];
      // A pointer outside the node range starts the scan at node zero.
      start_q  <= ({1'b0, ptr_q} < n_nodes) ? ptr_q : '0;
      node_q   <= '0;
      cafter_q <= '0;
    end
    if (issue) begin
      chk_idx_q  <= rd_idx;
      chk_last_q <= (k_q == n_nodes - CNT_W'(1));
    end
    if ((state_q == ST_SCAN) && hit) begin
      node_q   <= chk_idx_q;
      cafter_q <= rd_credit;
    end
    if ((state_q == ST_UPDATE) && is_claim) begin
      cafter_q <= cafter_q - CREDIT_W'(1);
    end
    if (load_out) begin
      m_data_q <= {2'b00, cafter_q, (gnt_q && is_claim) ? caddr_q : laddr_q,
                   node_q, gnt_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The credit memory is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.rd_en |-> !store_req.wr_en && !store_req.dflt_en)
    else $error("credit store read overlaps a write");

  // The scan never issues more reads than there are nodes.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (k_q <= n_nodes))
    else $error("scan ran past the node count");

  // A granted claim never hands work to this node.
  a_not_own: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && gnt_q) |-> (node_q != own_q))
    else $error("own node chosen as destination");

  // A result is only loaded when the output register can take it.
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !load_out)
    else $error("pending result overwritten");

endmodule
